FILE: hw/rtl/tlms_pkg.sv
package tlms_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned RegW   = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned IdxW   = 3;

  localparam logic [PhaseW-1:0] PhIdle = 3'd0;
  localparam logic [PhaseW-1:0] PhRise = 3'd1;
  localparam logic [PhaseW-1:0] PhHold = 3'd2;
  localparam logic [PhaseW-1:0] PhDesc = 3'd3;
  localparam logic [PhaseW-1:0] PhAdjU = 3'd4;
  localparam logic [PhaseW-1:0] PhAdjD = 3'd5;
  localparam logic [PhaseW-1:0] PhFin  = 3'd6;

  localparam logic [IdxW-1:0] RegInitRolls = 3'd0;
  localparam logic [IdxW-1:0] RegHoldUp    = 3'd1;
  localparam logic [IdxW-1:0] RegDescend   = 3'd2;
  localparam logic [IdxW-1:0] RegAdjUp     = 3'd3;
  localparam logic [IdxW-1:0] RegAdjDown   = 3'd4;
  localparam logic [IdxW-1:0] RegFinDown   = 3'd5;

  localparam logic [RegW-1:0] InitRollsRst = 16'd2;
  localparam logic [RegW-1:0] HoldUpRst    = 16'd12;
  localparam logic [RegW-1:0] DescendRst   = 16'd10;
  localparam logic [RegW-1:0] AdjUpRst     = 16'd6;
  localparam logic [RegW-1:0] AdjDownRst   = 16'd5;
  localparam logic [RegW-1:0] FinDownRst   = 16'd10;

  localparam logic [31:0] TimerMax = 32'((64'd1 << TimerW) - 64'd1);

  typedef struct packed {
    logic [RegW-1:0] init_rolls;
    logic [RegW-1:0] hold_up;
    logic [RegW-1:0] descend;
    logic [RegW-1:0] adj_up;
    logic [RegW-1:0] adj_down;
    logic [RegW-1:0] fin_down;
  } cfg_t;

  typedef struct packed {
    logic [RegW-1:0]   rolls;
    logic [PhaseW-1:0] phase;
    logic              motor_down;
    logic              motor_up;
  } res_t;

  // zero acts as one, saturate to timer range
  function automatic logic [TimerW-1:0] load_time(input logic [RegW-1:0] d);
    logic [31:0] v;
    v = (d == '0) ? 32'd1 : 32'(d);
    if (v > TimerMax) v = TimerMax;
    return v[TimerW-1:0];
  endfunction

endpackage

FILE: hw/rtl/tlms_cfg_regs.sv
module tlms_cfg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [tlms_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [tlms_pkg::RegW-1:0] cfg_data_i,
  output tlms_pkg::cfg_t        cfg_o,
  output logic                  roll_load_o
);
  import tlms_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInitRolls: cfg_d.init_rolls = cfg_data_i;
        RegHoldUp:    cfg_d.hold_up    = cfg_data_i;
        RegDescend:   cfg_d.descend    = cfg_data_i;
        RegAdjUp:     cfg_d.adj_up     = cfg_data_i;
        RegAdjDown:   cfg_d.adj_down   = cfg_data_i;
        RegFinDown:   cfg_d.fin_down   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{init_rolls: InitRollsRst, hold_up: HoldUpRst, descend: DescendRst,
                 adj_up: AdjUpRst, adj_down: AdjDownRst, fin_down: FinDownRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o       = cfg_q;
  assign roll_load_o = cfg_we_i && (cfg_idx_i == RegInitRolls);

endmodule

FILE: hw/rtl/tlms_phase_fsm.sv
module tlms_phase_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      ir_i,
  input  tlms_pkg::cfg_t            cfg_i,
  input  logic                      roll_load_i,
  input  logic [tlms_pkg::RegW-1:0] roll_load_val_i,
  output tlms_pkg::res_t            res_o
);
  import tlms_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [RegW-1:0]   roll_q, roll_d;
  logic              timed, done;

  assign timed = (phase_q >= PhHold) && (phase_q <= PhFin);
  assign done  = timed && (timer_q <= TimerW'(1));

  always_comb begin
    phase_d = phase_q;
    timer_d = (timed && !done) ? timer_q - TimerW'(1) : timer_q;
    roll_d  = roll_q;
    case (phase_q)
      PhIdle: begin
        if (ir_i && roll_q != '0) begin
          phase_d = PhRise;
          timer_d = '0;
        end
      end
      PhRise: begin
        if (!ir_i) begin
          phase_d = PhHold;
          timer_d = load_time(cfg_i.hold_up);
        end
      end
      PhHold: begin
        if (done) begin
          phase_d = PhDesc;
          timer_d = load_time(cfg_i.descend);
        end
      end
      PhDesc, PhAdjD: begin
        if (done) begin
          if (ir_i) begin
            phase_d = PhAdjU;
            timer_d = load_time(cfg_i.adj_up);
          end else begin
            phase_d = PhFin;
            timer_d = load_time(cfg_i.fin_down);
          end
        end
      end
      PhAdjU: begin
        if (done) begin
          phase_d = PhAdjD;
          timer_d = load_time(cfg_i.adj_down);
        end
      end
      PhFin: begin
        if (done) begin
          if (roll_q != '0) roll_d = roll_q - RegW'(1);
          phase_d = PhIdle;
          timer_d = '0;
        end
      end
      default: begin
        phase_d = PhIdle;
        timer_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      timer_q <= '0;
      roll_q  <= InitRollsRst;
    end else begin
      if (step_i) begin
        phase_q <= phase_d;
        timer_q <= timer_d;
        roll_q  <= roll_d;
      end else if (roll_load_i) begin
        roll_q  <= roll_load_val_i;
      end
    end
  end

  assign res_o.rolls      = roll_d;
  assign res_o.phase      = phase_d;
  assign res_o.motor_up   = (phase_d == PhRise) || (phase_d == PhHold) || (phase_d == PhAdjU);
  assign res_o.motor_down = (phase_d == PhDesc) || (phase_d == PhAdjD) || (phase_d == PhFin);

  a_fin_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PhFin && done |=> phase_q == PhIdle)
    else $error("final phase did not return to idle");

  a_roll_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i && !roll_load_i |=> $stable(roll_q))
    else $error("roll count moved without a request");

  a_roll_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> roll_q <= $past(roll_q))
    else $error("roll count increased on a request");

  a_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_d >= PhHold && phase_d <= PhFin |=> timer_q != '0)
    else $error("timed phase entered with empty timer");

endmodule

FILE: hw/rtl/timed_lift_motor_sequencer_unit.sv
// Channel | Dir | tdata fields (low bit up)                         | Width
// s_axis  | in  | ir_level[0], zero pad [7:1]                       | 8
// m_axis  | out | motor_up, motor_down, phase_now[3], rolls_left[16], | 24
//         |     | zero pad [23:21]                                  |
// cfg     | in  | cfg_we_i, cfg_idx_i (0..5), cfg_data_i[15:0]      | 16
// One request per cycle sustained while m_axis_tready is high; path: input register, then result register.
// Phase, timer and roll count advance only when the input register hands off to the result.
// Result register stalls on m_axis_tready low; input side keeps accepting into a free input reg.
// Reset: idle, timer zero, roll count 2, registers at their defaults.
module timed_lift_motor_sequencer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // ir_level
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // motor_up, motor_down, phase_now, rolls_left
  input  logic                      cfg_we_i,
  input  logic [tlms_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [tlms_pkg::RegW-1:0] cfg_data_i
);
  import tlms_pkg::*;

  cfg_t cfg;
  res_t res, res_q;
  logic roll_load;
  logic in_valid_q, ir_q, out_valid_q;
  logic advance, step;

  tlms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .roll_load_o (roll_load)
  );

  tlms_phase_fsm u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .ir_i            (ir_q),
    .cfg_i           (cfg),
    .roll_load_i     (roll_load),
    .roll_load_val_i (cfg_data_i),
    .res_o           (res)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) ir_q <= s_axis_tdata[0];
    if (step) res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.rolls, res_q.phase, res_q.motor_down, res_q.motor_up};

endmodule
